FILE: rtl/plic_pkg.sv
// Shared types and codes for the pinned LRU image cache.
// Used by plic_cell and pinned_lru_image_cache_unit; no dependencies.
package plic_pkg;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_MISS      = 3'd1;
    localparam logic [2:0] ST_STORED    = 3'd2;
    localparam logic [2:0] ST_ABSENT    = 3'd3;
    localparam logic [2:0] ST_NO_VICTIM = 3'd4;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_STORE  = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [13:0] width;
        logic [13:0] height;
        logic [31:0] handle;
        logic [63:0] stamp;
    } t_entry;

    typedef struct packed {
        logic        fill;
        logic        touch;
        logic [31:0] key;
        logic [13:0] width;
        logic [13:0] height;
        logic [31:0] handle;
        logic [63:0] stamp;
    } t_wr;

endpackage

FILE: rtl/plic_cell.sv
// One cache entry cell: holds an entry and passes the scan token to its neighbor.
// Depends on plic_pkg.
module plic_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tok,
    output logic           o_tok,
    input  logic           i_sel,
    input  plic_pkg::t_wr  i_wr,
    output plic_pkg::t_entry o_entry
);
    import plic_pkg::*;

    logic        r_tok;
    logic        r_valid;
    logic [31:0] r_key;
    logic [13:0] r_width;
    logic [13:0] r_height;
    logic [31:0] r_handle;
    logic [63:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (i_sel && i_wr.fill) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel && i_wr.fill) begin
            r_key    <= i_wr.key;
            r_width  <= i_wr.width;
            r_height <= i_wr.height;
            r_handle <= i_wr.handle;
        end
        if (i_sel && (i_wr.fill || i_wr.touch)) begin
            r_stamp <= i_wr.stamp;
        end
    end

    assign o_tok = r_tok;

    // drive the shared bus only while holding the token
    always_comb begin
        o_entry = '0;
        if (r_tok) begin
            o_entry.valid  = r_valid;
            o_entry.key    = r_key;
            o_entry.width  = r_width;
            o_entry.height = r_height;
            o_entry.handle = r_handle;
            o_entry.stamp  = r_stamp;
        end
    end

endmodule

FILE: rtl/pinned_lru_image_cache_unit.sv
// Pinned LRU image cache: a token walks a chain of ENTRIES cells, one per cycle.
// Each request passes S_IDLE, S_SCAN, S_LAST and S_DECIDE; one transaction at a time,
// so no new request is taken until the walk down the chain and the decide are done.
// The next request is taken while a result waits on a stalled output.
// Synchronous active-low reset empties the cache, clears pins and sets monitor_mask to 1.
module pinned_lru_image_cache_unit #(
    parameter int ENTRIES  = 64,
    parameter int MONITORS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [0:0]  i_req_type,
    input  logic [31:0] i_image_key,
    input  logic [13:0] i_width,
    input  logic [13:0] i_height,
    input  logic [31:0] i_handle_in,
    input  logic [4:0]  i_monitor,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_handle_out,
    output logic [0:0]  o_freed_valid,
    output logic [31:0] o_freed_handle,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import plic_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_DECIDE} t_state;

    t_state      r_state;
    logic [31:0] r_mask;
    logic [31:0] r_cur [MONITORS];
    logic [63:0] r_clock;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_idx;

    logic        r_req;
    logic [31:0] r_key;
    logic [13:0] r_w;
    logic [13:0] r_h;
    logic [31:0] r_hin;
    logic [4:0]  r_mon;

    t_entry      r_c;
    logic        r_cv;
    logic [IW-1:0] r_cidx;

    logic        r_mf;
    logic [IW-1:0] r_midx;
    logic [31:0] r_mhandle;
    logic        r_ff;
    logic [IW-1:0] r_fidx;
    logic        r_vf;
    logic [IW-1:0] r_vidx;
    logic [63:0] r_vstamp;
    logic [31:0] r_vhandle;

    logic        r_ovalid;
    logic [2:0]  r_status;
    logic [31:0] r_hout;
    logic        r_fvalid;
    logic [31:0] r_fhandle;

    logic        in_acc;
    logic        out_free;
    logic [ENTRIES:0] tok;
    t_entry      ent [ENTRIES];
    t_entry      bus;
    logic [ENTRIES-1:0] sel;
    t_wr         wr;

    logic        c_match;
    logic        c_pin;

    logic        n_we;
    logic [IW-1:0] n_slot;
    logic [2:0]  n_status;
    logic [31:0] n_hout;
    logic        n_fvalid;
    logic [31:0] n_fhandle;
    logic        n_pin;
    logic        n_inc;
    logic        mon_ok;
    logic        present;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // token chain
    assign tok[0] = in_acc;
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        plic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1]),
            .i_sel   (sel[k]),
            .i_wr    (wr),
            .o_entry (ent[k])
        );
        assign sel[k] = n_we && (n_slot == IW'(k));
    end

    always_comb begin
        bus = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            bus = bus | ent[k];
        end
    end

    // candidate checks on the registered entry
    assign c_match = r_c.valid && (r_c.key == r_key) && (r_c.width == r_w)
                     && (r_c.height == r_h);

    always_comb begin
        c_pin = 1'b0;
        for (int m = 0; m < MONITORS; m++) begin
            if (r_mask[m] && (r_cur[m] == r_c.handle)) begin
                c_pin = 1'b1;
            end
        end
        if (r_c.handle == 32'd0) begin
            c_pin = 1'b0;
        end
    end

    assign mon_ok  = (32'(r_mon) < 32'(MONITORS));
    assign present = mon_ok && r_mask[r_mon];

    always_comb begin
        n_we      = 1'b0;
        n_slot    = r_midx;
        n_status  = ST_MISS;
        n_hout    = 32'd0;
        n_fvalid  = 1'b0;
        n_fhandle = 32'd0;
        n_pin     = 1'b0;
        n_inc     = 1'b0;
        wr        = '0;
        wr.key    = r_key;
        wr.width  = r_w;
        wr.height = r_h;
        wr.handle = r_hin;
        wr.stamp  = r_clock + 64'd1;
        if (r_state == S_DECIDE && out_free) begin
            if (r_req == REQ_LOOKUP) begin
                if (r_mf) begin
                    n_status = ST_HIT;
                    n_hout   = r_mhandle;
                    n_we     = 1'b1;
                    wr.touch = 1'b1;
                    n_pin    = mon_ok;
                end
            end else if (!present) begin
                n_status = ST_ABSENT;
            end else if (r_mf) begin
                n_status  = ST_STORED;
                n_we      = 1'b1;
                wr.fill   = 1'b1;
                n_pin     = 1'b1;
                n_fvalid  = (r_mhandle != r_hin);
                n_fhandle = n_fvalid ? r_mhandle : 32'd0;
            end else if (r_cnt >= CW'(ENTRIES)) begin
                if (r_vf) begin
                    n_status  = ST_STORED;
                    n_slot    = r_vidx;
                    n_we      = 1'b1;
                    wr.fill   = 1'b1;
                    n_pin     = 1'b1;
                    n_fvalid  = 1'b1;
                    n_fhandle = r_vhandle;
                end else begin
                    n_status = ST_NO_VICTIM;
                end
            end else if (r_ff) begin
                n_status = ST_STORED;
                n_slot   = r_fidx;
                n_we     = 1'b1;
                wr.fill  = 1'b1;
                n_pin    = 1'b1;
                n_inc    = 1'b1;
            end else begin
                n_status = ST_NO_VICTIM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mask   <= 32'd1;
            r_clock  <= 64'd0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_cv     <= 1'b0;
            r_ovalid <= 1'b0;
            for (int m = 0; m < MONITORS; m++) begin
                r_cur[m] <= 32'd0;
            end
        end else begin
            if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
                r_mask <= pwdata;
            end
            // decide owns the result register while it runs
            if (r_ovalid && !i_out_stall && (r_state != S_DECIDE)) begin
                r_ovalid <= 1'b0;
            end
            if (r_cv) begin
                if (c_match && !r_mf) begin
                    r_mf      <= 1'b1;
                    r_midx    <= r_cidx;
                    r_mhandle <= r_c.handle;
                end
                if (!r_c.valid && !r_ff) begin
                    r_ff   <= 1'b1;
                    r_fidx <= r_cidx;
                end
                if (r_c.valid && !c_pin && (!r_vf || (r_c.stamp < r_vstamp))) begin
                    r_vf      <= 1'b1;
                    r_vidx    <= r_cidx;
                    r_vstamp  <= r_c.stamp;
                    r_vhandle <= r_c.handle;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req <= i_req_type;
                        r_key <= i_image_key;
                        r_w   <= i_width;
                        r_h   <= i_height;
                        r_hin <= i_handle_in;
                        r_mon <= i_monitor;
                        r_mf  <= 1'b0;
                        r_ff  <= 1'b0;
                        r_vf  <= 1'b0;
                        r_idx <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // capture the cell holding the token
                    r_c    <= bus;
                    r_cidx <= r_idx;
                    r_cv   <= 1'b1;
                    r_idx  <= r_idx + IW'(1);
                    if (r_idx == IW'(ENTRIES - 1)) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_cv    <= 1'b0;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_status  <= n_status;
                        r_hout    <= n_hout;
                        r_fvalid  <= n_fvalid;
                        r_fhandle <= n_fhandle;
                        if (n_we) begin
                            r_clock <= r_clock + 64'd1;
                        end
                        if (n_inc) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        for (int m = 0; m < MONITORS; m++) begin
                            if (n_pin && (r_mon == 5'(m))) begin
                                r_cur[m] <= (r_req == REQ_LOOKUP) ? r_mhandle : r_hin;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_status;
    assign o_handle_out   = r_hout;
    assign o_freed_valid  = r_fvalid;
    assign o_freed_handle = r_fhandle;
    assign prdata = (paddr[2] == 1'b0) ? r_mask : 32'd0;
    assign pready = 1'b1;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(ENTRIES))
        else $error("entry count above capacity");
    a_tok_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok[ENTRIES:1]))
        else $error("more than one scan token in the chain");
    a_freed_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_freed_valid |-> o_status == ST_STORED)
        else $error("freed handle without a store");
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DECIDE))
        else $error("result raised outside decide");

endmodule

FILE: dv/tb_top.sv
// Testbench for pinned_lru_image_cache_unit: random and directed lookups and stores
// checked against a built-in cache predictor. Depends on rtl/plic_pkg.sv and the RTL top.
`timescale 1ns / 1ps

module tb_top;
    import plic_pkg::*;

    localparam int NENT = 64;
    localparam int NMON = 32;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] handle_out;
        logic        freed_valid;
        logic [31:0] freed_handle;
    } t_reply;

    class cache_scoreboard;
        bit          ent_ok [NENT];
        bit [31:0]   ent_key [NENT];
        bit [13:0]   ent_w [NENT];
        bit [13:0]   ent_h [NENT];
        bit [31:0]   ent_hdl [NENT];
        bit [63:0]   ent_stamp [NENT];
        bit [63:0]   use_clock;
        int          fill_count;
        bit [31:0]   shown [NMON];
        bit [31:0]   mon_mask;
        t_reply      pending[$];
        int          errors;
        int          checked;
        int          hits;
        int          evictions;
        int          no_victim;

        function new();
            mon_mask = 32'd1;
        endfunction

        function bit present(bit [4:0] m);
            return mon_mask[m];
        endfunction

        function bit pinned(bit [31:0] h);
            if (h == 0) return 0;
            for (int m = 0; m < NMON; m++)
                if (present(5'(m)) && shown[m] == h) return 1;
            return 0;
        endfunction

        function void note_request(bit rq, bit [31:0] key, bit [13:0] w, bit [13:0] h,
                                   bit [31:0] hin, bit [4:0] mon);
            t_reply r;
            int slot;
            r = '0;
            slot = -1;
            for (int i = 0; i < NENT; i++)
                if (slot < 0 && ent_ok[i] && ent_key[i] == key && ent_w[i] == w
                    && ent_h[i] == h)
                    slot = i;
            if (rq == REQ_LOOKUP) begin
                if (slot >= 0) begin
                    use_clock++;
                    ent_stamp[slot] = use_clock;
                    r.handle_out = ent_hdl[slot];
                    shown[mon] = ent_hdl[slot];
                    r.status = ST_HIT;
                    hits++;
                end else begin
                    r.status = ST_MISS;
                end
            end else if (!present(mon)) begin
                r.status = ST_ABSENT;
            end else begin
                r.status = ST_STORED;
                if (slot >= 0) begin
                    if (ent_hdl[slot] != hin) begin
                        r.freed_valid = 1;
                        r.freed_handle = ent_hdl[slot];
                    end
                end else if (fill_count >= NENT) begin
                    for (int i = 0; i < NENT; i++) begin
                        if (!ent_ok[i] || pinned(ent_hdl[i])) continue;
                        if (slot < 0 || ent_stamp[i] < ent_stamp[slot]) slot = i;
                    end
                    if (slot < 0) begin
                        r.status = ST_NO_VICTIM;
                        no_victim++;
                    end else begin
                        r.freed_valid = 1;
                        r.freed_handle = ent_hdl[slot];
                        evictions++;
                    end
                end else begin
                    for (int i = 0; i < NENT; i++)
                        if (slot < 0 && !ent_ok[i]) slot = i;
                    fill_count++;
                end
                if (r.status == ST_STORED) begin
                    ent_ok[slot] = 1;
                    ent_key[slot] = key;
                    ent_w[slot] = w;
                    ent_h[slot] = h;
                    ent_hdl[slot] = hin;
                    use_clock++;
                    ent_stamp[slot] = use_clock;
                    shown[mon] = hin;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_reply(t_reply got);
            t_reply exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st=%0d h=%h fv=%0d fh=%h got st=%0d h=%h fv=%0d fh=%h",
                             exp_r.status, exp_r.handle_out, exp_r.freed_valid,
                             exp_r.freed_handle, got.status, got.handle_out,
                             got.freed_valid, got.freed_handle);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [0:0]  i_req_type = 0;
    logic [31:0] i_image_key = 0;
    logic [13:0] i_width = 1;
    logic [13:0] i_height = 1;
    logic [31:0] i_handle_in = 0;
    logic [4:0]  i_monitor = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [2:0]  o_status;
    logic [31:0] o_handle_out;
    logic [0:0]  o_freed_valid;
    logic [31:0] o_freed_handle;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    pinned_lru_image_cache_unit u_top (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    cache_scoreboard sb = new();
    bit long_hold;
    bit stim_done;
    int sent;

    initial begin
        #200_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    // sample results; stall control lives here
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reply('{o_status, o_handle_out, o_freed_valid, o_freed_handle});
        if (long_hold)
            i_out_stall <= 1;
        else if ($urandom_range(0, 3) == 0)
            i_out_stall <= ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(0, 1);
        else
            i_out_stall <= 0;
    end

    function int gap_len();
        if ($urandom_range(0, 1)) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
        return $urandom_range(1, 4);
    endfunction

    task automatic send(bit rq, bit [31:0] key, bit [13:0] w, bit [13:0] h,
                        bit [31:0] hin, bit [4:0] mon, bit gaps);
        int g;
        i_in_valid <= 1;
        i_req_type <= rq;
        i_image_key <= key;
        i_width <= w;
        i_height <= h;
        i_handle_in <= hin;
        i_monitor <= mon;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(rq, key, w, h, hin, mon);
        sent++;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_mask(bit [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.mon_mask = v;
        @(posedge i_clk);
    endtask

    // small key pool so lookups hit and stores replace
    task automatic random_item(int pool);
        bit [31:0] key;
        bit [13:0] w, h;
        bit [31:0] hin;
        key = $urandom_range(0, pool);
        if ($urandom_range(0, 9) == 0) key = $urandom;
        w = ($urandom_range(0, 7) == 0) ? 14'($urandom_range(1, 16383)) : 14'($urandom_range(1, 2));
        h = ($urandom_range(0, 7) == 0) ? 14'($urandom_range(1, 16383)) : 14'($urandom_range(1, 2));
        hin = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 90));
        send(1'($urandom_range(0, 1)), key, w, h, hin, 5'($urandom), 1);
    endtask

    initial begin
        bit [31:0] masks [5];
        masks = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_000F, 32'h8000_0101};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, misses, absent monitor, replacement, zero handle
        send(REQ_LOOKUP, 0, 1, 1, 0, 0, 0);
        send(REQ_STORE, 32'hFFFF_FFFF, 14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF, 0, 0);
        send(REQ_LOOKUP, 32'hFFFF_FFFF, 14'h3FFF, 14'h3FFF, 0, 31, 0);
        send(REQ_STORE, 5, 1, 1, 7, 31, 0);
        send(REQ_STORE, 5, 1, 1, 7, 0, 0);
        send(REQ_STORE, 5, 1, 1, 7, 0, 0);
        send(REQ_STORE, 5, 1, 1, 9, 0, 0);
        send(REQ_STORE, 6, 2, 3, 0, 0, 0);
        send(REQ_LOOKUP, 6, 2, 3, 0, 0, 0);
        send(REQ_LOOKUP, 6, 3, 2, 0, 0, 0);
        // fill then overflow: only monitor 0's last entry is pinned, so LRU evicts
        for (int i = 0; i < 66; i++)
            send(REQ_STORE, 32'h1000 + i, 1, 1, 32'h100 + i, 0, 0);
        drain();
        // every monitor pins a distinct entry; with full cache only unpinned evict
        write_mask(32'hFFFF_FFFF);
        for (int m = 0; m < 32; m++)
            send(REQ_LOOKUP, 32'h1000 + 2 + m, 1, 1, 0, 5'(m), 0);
        for (int i = 0; i < 40; i++)
            send(REQ_STORE, 32'h2000 + i, 1, 1, 32'h200 + i, 5'(i % 32), 0);
        drain();

        for (int p = 0; p < 5; p++) begin
            write_mask(masks[p]);
            for (int n = 0; n < 400; n++) begin
                if (p == 1 && n == 100) begin
                    long_hold = 1;
                    fork
                        begin repeat (400) @(posedge i_clk); long_hold = 0; end
                    join_none
                end
                random_item(p == 2 ? 20 : 120);
            end
            drain();
        end
        write_mask($urandom);
        for (int n = 0; n < 100; n++) random_item(60);
        drain();

        $display("sent %0d requests, checked %0d results: %0d hits, %0d evictions, %0d no-victim",
                 sent, sb.checked, sb.hits, sb.evictions, sb.no_victim);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
